// File: hdl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg
// Shared types, constants and width helpers for the thresholded centroid block.
// ----------------------------------------------------------------------------
package tbc_pkg;

	localparam int DEF_MAX_WIDTH     = 4096;
	localparam int DEF_MAX_HEIGHT    = 4096;
	localparam int DEF_FRACTION_BITS = 4;

	localparam logic [7:0]  THRESH_RESET = 8'd10;
	localparam logic [12:0] WIDTH_RESET  = 13'd1200;
	localparam logic [15:0] COORD_MAX    = 16'hFFFF;

	localparam int FQ_DEPTH = 2;

	localparam logic REG_THRESH = 1'b0;
	localparam logic REG_WIDTH  = 1'b1;

	typedef struct packed {
		logic [7:0] pixel_value;
		logic       frame_end;
	} pix_t;

	typedef struct packed {
		logic [15:0] center_x;
		logic [15:0] center_y;
		logic [24:0] bright_count;
		logic        empty_frame;
	} res_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fq_stat_t;

	function automatic int tally_w(int mw, int mh);
		return $clog2(longint'(mw) * longint'(mh) + 64'd1);
	endfunction

	function automatic int sum_w(int mw, int mh, int dim);
		return $clog2(longint'(mw) * longint'(mh)) + $clog2(dim);
	endfunction

endpackage

// File: hdl/threshold_blob_centroid.sv
// ----------------------------------------------------------------------------
// threshold_blob_centroid
// Centroid of the pixels above a threshold, one result word per frame.
// ----------------------------------------------------------------------------
// channel  | handshake          | word
// ---------+--------------------+-------------------------------------------
// pixel    | push / full        | pixel_value, frame_end
// result   | pop / empty        | center_x, center_y, bright_count, empty_frame
// config   | psel/penable/pready| brightness_threshold @0x0, frame_width @0x4
//
// Takes one pixel word per cycle while full is low; the accumulator itself never stalls.
// Each frame end queues its totals; the divider takes DW dividend bits per
// frame (DW = sum width + fraction bits, 40 at the default sizes), one bit a cycle.
// full rises only while two frames of totals wait for the divider.
// Reset clears counters, sums, queue and result valid flag; no clearing pass.
// ----------------------------------------------------------------------------
module threshold_blob_centroid #(
	parameter int MAX_WIDTH     = tbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = tbc_pkg::DEF_MAX_HEIGHT,
	parameter int FRACTION_BITS = tbc_pkg::DEF_FRACTION_BITS
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	output logic           full,
	input  tbc_pkg::pix_t  pixel,
	output logic           empty,
	input  logic           pop,
	output tbc_pkg::res_t  result,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [2:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready
);
	import tbc_pkg::*;

	localparam int FQW = sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH) +
	                     sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_HEIGHT) +
	                     tally_w(MAX_WIDTH, MAX_HEIGHT);

	logic [7:0]     thr_q;
	logic [12:0]    fw_q;
	logic           accept, cfg_wr;
	logic           frame_push, fq_pop, res_valid;
	logic [FQW-1:0] fq_wdata, fq_rdata;
	fq_stat_t       fq_stat;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESH_RESET;
			fw_q  <= WIDTH_RESET;
		end else if (cfg_wr) begin
			case (paddr[2])
				REG_THRESH: thr_q <= pwdata[7:0];
				REG_WIDTH:  fw_q  <= pwdata[12:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_THRESH: prdata = 32'(thr_q);
			REG_WIDTH:  prdata = 32'(fw_q);
			default:    prdata = '0;
		endcase
	end

	assign full   = fq_stat.full;
	assign accept = push && !full;
	assign empty  = !res_valid;

	tbc_front #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.pixel       (pixel),
		.threshold   (thr_q),
		.frame_width (fw_q),
		.frame_push  (frame_push),
		.totals      (fq_wdata)
	);

	tbc_fifo #(
		.WIDTH (FQW),
		.DEPTH (FQ_DEPTH)
	) u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (frame_push),
		.wdata  (fq_wdata),
		.rd     (fq_pop),
		.rdata  (fq_rdata),
		.stat   (fq_stat)
	);

	tbc_div #(
		.MAX_WIDTH     (MAX_WIDTH),
		.MAX_HEIGHT    (MAX_HEIGHT),
		.FRACTION_BITS (FRACTION_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.fq_stat   (fq_stat),
		.totals    (fq_rdata),
		.fq_pop    (fq_pop),
		.res_pop   (pop && !empty),
		.res_valid (res_valid),
		.result    (result)
	);

`ifndef SYNTH
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && result.empty_frame) |->
			(result.center_x == 16'd0 && result.center_y == 16'd0 &&
			 result.bright_count == 25'd0))
		else $error("empty frame with non-zero fields");

	a_fq_underrun: assert property (@(posedge clk) disable iff (!arst_n)
		fq_pop |-> !fq_stat.empty)
		else $error("divider took totals from an empty queue");

	a_fq_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(fq_stat.full && !fq_pop) |=> fq_stat.full)
		else $error("frame totals lost from a full queue");
`endif

endmodule

// File: hdl/tbc_front.sv
// ----------------------------------------------------------------------------
// tbc_front
// Raster position tracking, thresholding and per-frame accumulation.
// ----------------------------------------------------------------------------
module tbc_front #(
	parameter int MAX_WIDTH  = tbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = tbc_pkg::DEF_MAX_HEIGHT
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  tbc_pkg::pix_t       pixel,
	input  logic [7:0]          threshold,
	input  logic [12:0]         frame_width,
	output logic                frame_push,
	output logic [tbc_pkg::sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH) +
	              tbc_pkg::sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_HEIGHT) +
	              tbc_pkg::tally_w(MAX_WIDTH, MAX_HEIGHT) - 1:0] totals
);
	import tbc_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);
	localparam int XW = sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH);
	localparam int YW = sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_HEIGHT);
	localparam int TW = tally_w(MAX_WIDTH, MAX_HEIGHT);
	localparam longint unsigned TALLY_CAP = longint'(MAX_WIDTH) * longint'(MAX_HEIGHT);
	localparam int WW = (CW + 1 > 13) ? CW + 1 : 13;

	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic [XW-1:0] sx_q, sx_n;
	logic [YW-1:0] sy_q, sy_n;
	logic [TW-1:0] tally_q, tally_n;
	logic          hit;
	logic [WW-1:0] eff_w, col_inc;
	logic          wrap;

	assign hit     = (pixel.pixel_value > threshold) && (tally_q < TW'(TALLY_CAP));
	assign sx_n    = hit ? sx_q + XW'(col_q) : sx_q;
	assign sy_n    = hit ? sy_q + YW'(row_q) : sy_q;
	assign tally_n = hit ? tally_q + TW'(1) : tally_q;

	always_comb begin
		if (frame_width == 13'd0) begin
			eff_w = WW'(1);
		end else if (WW'(frame_width) > WW'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(frame_width);
		end
	end

	assign col_inc = WW'(col_q) + WW'(1);
	assign wrap    = col_inc >= eff_w;

	assign frame_push = accept && pixel.frame_end;
	assign totals     = {sx_n, sy_n, tally_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			tally_q <= '0;
		end else if (accept) begin
			if (pixel.frame_end) begin
				col_q   <= '0;
				row_q   <= '0;
				sx_q    <= '0;
				sy_q    <= '0;
				tally_q <= '0;
			end else begin
				sx_q    <= sx_n;
				sy_q    <= sy_n;
				tally_q <= tally_n;
				if (wrap) begin
					col_q <= '0;
					if (row_q != RW'(MAX_HEIGHT - 1))
						row_q <= row_q + RW'(1);
				end else begin
					col_q <= CW'(col_inc);
				end
			end
		end
	end

endmodule

// File: hdl/tbc_fifo.sv
// ----------------------------------------------------------------------------
// tbc_fifo
// Short queue of frame totals between the accumulator and the divider.
// ----------------------------------------------------------------------------
module tbc_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tbc_pkg::FQ_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 wr,
	input  logic [WIDTH-1:0]     wdata,
	input  logic                 rd,
	output logic [WIDTH-1:0]     rdata,
	output tbc_pkg::fq_stat_t    stat
);
	import tbc_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wp_q, rp_q;
	logic [NW-1:0]    cnt_q;
	logic             do_wr, do_rd;

	assign stat.full  = cnt_q == NW'(DEPTH);
	assign stat.empty = cnt_q == '0;
	assign do_wr      = wr && !stat.full;
	assign do_rd      = rd && !stat.empty;
	assign rdata      = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (do_wr)
			mem_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_wr)
				wp_q <= (wp_q == PW'(DEPTH - 1)) ? '0 : wp_q + PW'(1);
			if (do_rd)
				rp_q <= (rp_q == PW'(DEPTH - 1)) ? '0 : rp_q + PW'(1);
			if (do_wr && !do_rd)
				cnt_q <= cnt_q + NW'(1);
			else if (do_rd && !do_wr)
				cnt_q <= cnt_q - NW'(1);
		end
	end

endmodule

// File: hdl/tbc_div.sv
// ----------------------------------------------------------------------------
// tbc_div
// Restoring divider for both centroid coordinates, with the result register.
// ----------------------------------------------------------------------------
module tbc_div #(
	parameter int MAX_WIDTH     = tbc_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT    = tbc_pkg::DEF_MAX_HEIGHT,
	parameter int FRACTION_BITS = tbc_pkg::DEF_FRACTION_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tbc_pkg::fq_stat_t   fq_stat,
	input  logic [tbc_pkg::sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH) +
	              tbc_pkg::sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_HEIGHT) +
	              tbc_pkg::tally_w(MAX_WIDTH, MAX_HEIGHT) - 1:0] totals,
	output logic                fq_pop,
	input  logic                res_pop,
	output logic                res_valid,
	output tbc_pkg::res_t       result
);
	import tbc_pkg::*;

	localparam int XW  = sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_WIDTH);
	localparam int YW  = sum_w(MAX_WIDTH, MAX_HEIGHT, MAX_HEIGHT);
	localparam int TW  = tally_w(MAX_WIDTH, MAX_HEIGHT);
	localparam int SW  = (XW > YW) ? XW : YW;
	localparam int DW  = SW + FRACTION_BITS;
	localparam int QX  = $clog2(MAX_WIDTH) + FRACTION_BITS;
	localparam int QY  = $clog2(MAX_HEIGHT) + FRACTION_BITS;
	localparam int CNW = $clog2(DW);

	typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_DONE} state_t;

	state_t         state_q;
	logic [CNW-1:0] cnt_q;
	logic [DW-1:0]  dx_q, dy_q;
	logic [TW:0]    rx_q, ry_q;
	logic [TW-1:0]  den_q;
	logic [QX-1:0]  qx_q;
	logic [QY-1:0]  qy_q;
	logic           res_valid_q;
	res_t           res_q;

	logic [XW-1:0]  in_sx;
	logic [YW-1:0]  in_sy;
	logic [TW-1:0]  in_t;
	logic [TW:0]    rx_sh, ry_sh;
	logic           gx, gy;
	logic           load_out;

	assign {in_sx, in_sy, in_t} = totals;

	assign rx_sh = {rx_q[TW-1:0], dx_q[DW-1]};
	assign ry_sh = {ry_q[TW-1:0], dy_q[DW-1]};
	assign gx    = rx_sh >= {1'b0, den_q};
	assign gy    = ry_sh >= {1'b0, den_q};

	assign fq_pop    = (state_q == ST_IDLE) && !fq_stat.empty;
	assign load_out  = (state_q == ST_DONE) && (!res_valid_q || res_pop);
	assign res_valid = res_valid_q;
	assign result    = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (!fq_stat.empty) begin
						dx_q    <= DW'(in_sx) << FRACTION_BITS;
						dy_q    <= DW'(in_sy) << FRACTION_BITS;
						den_q   <= in_t;
						rx_q    <= '0;
						ry_q    <= '0;
						qx_q    <= '0;
						qy_q    <= '0;
						cnt_q   <= CNW'(DW - 1);
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					dx_q  <= dx_q << 1;
					dy_q  <= dy_q << 1;
					rx_q  <= gx ? rx_sh - {1'b0, den_q} : rx_sh;
					ry_q  <= gy ? ry_sh - {1'b0, den_q} : ry_sh;
					qx_q  <= QX'({qx_q, gx});
					qy_q  <= QY'({qy_q, gy});
					cnt_q <= cnt_q - CNW'(1);
					if (cnt_q == '0)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (load_out)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase

			if (load_out) begin
				res_valid_q        <= 1'b1;
				res_q.bright_count <= 25'(den_q);
				res_q.empty_frame  <= den_q == '0;
				if (den_q == '0) begin
					res_q.center_x <= '0;
					res_q.center_y <= '0;
				end else begin
					res_q.center_x <= (qx_q > QX'(COORD_MAX)) ? COORD_MAX : 16'(qx_q);
					res_q.center_y <= (qy_q > QY'(COORD_MAX)) ? COORD_MAX : 16'(qy_q);
				end
			end else if (res_pop) begin
				res_valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for threshold_blob_centroid. Streams pixel words in
// raster order and tracks its own column/row position, sums and tally to
// predict each frame's centroid word. Every popped word is checked against
// the oldest prediction. Covers directed corner frames, tall and wide frames,
// width changes in the middle of a frame, result back-pressure and random
// frames under several register settings.
// ----------------------------------------------------------------------------
module testbench;
	import tbc_pkg::*;

	localparam longint TALLY_CAP = longint'(DEF_MAX_WIDTH) * longint'(DEF_MAX_HEIGHT);

	logic        clk;
	logic        arst_n;
	logic        push;
	logic        full;
	pix_t        pixel;
	logic        empty;
	logic        pop;
	res_t        result;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	threshold_blob_centroid dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.pixel   (pixel),
		.empty   (empty),
		.pop     (pop),
		.result  (result),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// centroid predictor state
	logic [7:0]  m_thresh;
	logic [12:0] m_width;
	logic [11:0] m_col;
	logic [11:0] m_row;
	logic [35:0] m_col_sum;
	logic [35:0] m_row_sum;
	logic [24:0] m_tally;

	res_t frame_results_q[$];

	int  errors;
	int  pixels_sent;
	int  frames_checked;
	int  stall_cycles;
	int  sink_hold;
	bit  src_idle_on;
	bit  sink_idle_on;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#8_000_000;
		$display("watchdog expired with %0d frame results outstanding",
			frame_results_q.size());
		$display("testbench: errors");
		$finish;
	end

	always @(posedge clk) begin
		if (push && full)
			stall_cycles++;
	end

	function automatic logic [15:0] mean_q4(input logic [35:0] sum, input logic [24:0] count);
		logic [63:0] q;
		if (count == 0)
			return 16'd0;
		q = ({28'd0, sum} << DEF_FRACTION_BITS) / {39'd0, count};
		if (q > {48'd0, COORD_MAX})
			return COORD_MAX;
		return q[15:0];
	endfunction

	function automatic void clear_frame_sums();
		m_col = '0;
		m_row = '0;
		m_col_sum = '0;
		m_row_sum = '0;
		m_tally = '0;
	endfunction

	function automatic void accumulate_pixel(input pix_t p);
		int unsigned w;
		res_t r;
		w = {19'd0, m_width};
		if (w == 0)
			w = 1;
		if (w > DEF_MAX_WIDTH)
			w = DEF_MAX_WIDTH;
		if (p.pixel_value > m_thresh && longint'(m_tally) < TALLY_CAP) begin
			m_col_sum += 36'(m_col);
			m_row_sum += 36'(m_row);
			m_tally++;
		end
		if (p.frame_end) begin
			r.center_x = mean_q4(m_col_sum, m_tally);
			r.center_y = mean_q4(m_row_sum, m_tally);
			r.bright_count = m_tally;
			r.empty_frame = (m_tally == 0);
			frame_results_q.push_back(r);
			clear_frame_sums();
		end else if (int'(m_col) + 1 >= w) begin
			m_col = '0;
			if (int'(m_row) + 1 < DEF_MAX_HEIGHT)
				m_row++;
		end else begin
			m_col++;
		end
	endfunction

	function automatic logic [7:0] pick_pixel();
		int t;
		case ($urandom_range(0, 7))
			0: t = 0;
			1: t = 255;
			2, 3: t = int'(m_thresh) + int'($urandom_range(0, 2)) - 1;
			default: t = $urandom_range(0, 255);
		endcase
		if (t < 0)
			t = 0;
		if (t > 255)
			t = 255;
		return t[7:0];
	endfunction

	task automatic check_result(input res_t got);
		res_t want;
		if (frame_results_q.size() == 0) begin
			if (errors < 10)
				$display("unexpected result word: x=%0d y=%0d count=%0d empty=%0b",
					got.center_x, got.center_y, got.bright_count, got.empty_frame);
			errors++;
		end else begin
			want = frame_results_q.pop_front();
			frames_checked++;
			if (got.center_x !== want.center_x || got.center_y !== want.center_y ||
				got.bright_count !== want.bright_count ||
				got.empty_frame !== want.empty_frame) begin
				if (errors < 10)
					$display("frame %0d: expected x=%0d y=%0d count=%0d empty=%0b, %s%0d %0d %0d %0b",
						frames_checked, want.center_x, want.center_y, want.bright_count,
						want.empty_frame, "got ", got.center_x, got.center_y,
						got.bright_count, got.empty_frame);
				errors++;
			end
		end
	endtask

	initial begin : result_sink
		int gap;
		pop = 1'b0;
		forever begin
			gap = sink_idle_on ? $urandom_range(0, 8) : 0;
			if (sink_hold > 0) begin
				gap = sink_hold;
				sink_hold = 0;
			end
			@(negedge clk);
			if (gap > 0) begin
				pop = 1'b0;
				repeat (gap) @(negedge clk);
			end
			pop = 1'b1;
			do @(posedge clk); while (empty);
			check_result(result);
		end
	end

	task automatic push_pixel(input pix_t p);
		int gap;
		gap = src_idle_on ? $urandom_range(0, 8) : 0;
		@(negedge clk);
		if (gap > 0) begin
			push = 1'b0;
			repeat (gap) @(negedge clk);
		end
		push = 1'b1;
		pixel = p;
		do @(posedge clk); while (full);
		accumulate_pixel(p);
		pixels_sent++;
	endtask

	task automatic send_pixels(input int count, input bit dark, input bit close_frame);
		pix_t p;
		for (int i = 0; i < count; i++) begin
			p.pixel_value = dark ? 8'($urandom_range(0, m_thresh)) : pick_pixel();
			p.frame_end = close_frame && (i == count - 1);
			push_pixel(p);
		end
	endtask

	// drop push, wait for every frame result, then let the divider run dry
	task automatic settle();
		@(negedge clk);
		push = 1'b0;
		while (frame_results_q.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
	endtask

	task automatic reg_access(input logic idx, input logic wr, input logic [31:0] wdata,
		output logic [31:0] rdata);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = wdata;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic read_check(input logic idx, input logic [31:0] want);
		logic [31:0] got;
		reg_access(idx, 1'b0, 32'd0, got);
		if (got !== want) begin
			if (errors < 10)
				$display("register %0d: expected %0d, read %0d", idx, want, got);
			errors++;
		end
	endtask

	task automatic cfg_write(input logic idx, input logic [31:0] value);
		logic [31:0] unused;
		reg_access(idx, 1'b1, value, unused);
		if (idx == REG_THRESH) begin
			m_thresh = value[7:0];
			read_check(idx, {24'd0, m_thresh});
		end else begin
			m_width = value[12:0];
			read_check(idx, {19'd0, m_width});
		end
	endtask

	task automatic test_register_defaults();
		read_check(REG_THRESH, {24'd0, THRESH_RESET});
		read_check(REG_WIDTH, {19'd0, WIDTH_RESET});
	endtask

	task automatic test_directed_frames();
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		push_pixel('{8'd255, 1'b1});
		push_pixel('{8'd10, 1'b1});
		push_pixel('{8'd11, 1'b0});
		push_pixel('{8'd0, 1'b0});
		push_pixel('{8'd255, 1'b1});
		settle();
		cfg_write(REG_WIDTH, 32'd2);
		cfg_write(REG_THRESH, 32'd0);
		push_pixel('{8'd1, 1'b0});
		push_pixel('{8'd1, 1'b0});
		push_pixel('{8'd1, 1'b0});
		push_pixel('{8'd0, 1'b1});
		settle();
		cfg_write(REG_THRESH, 32'd255);
		push_pixel('{8'd255, 1'b0});
		push_pixel('{8'd255, 1'b1});
		settle();
		cfg_write(REG_THRESH, 32'd254);
		cfg_write(REG_WIDTH, 32'd0);
		push_pixel('{8'd200, 1'b0});
		push_pixel('{8'd255, 1'b0});
		push_pixel('{8'd255, 1'b1});
		settle();
		cfg_write(REG_WIDTH, 32'd8191);
		push_pixel('{8'd255, 1'b0});
		push_pixel('{8'd128, 1'b0});
		push_pixel('{8'd255, 1'b1});
		settle();
	endtask

	// one row per pixel on a one-pixel-wide frame, then a partial row at the widest setting
	task automatic test_tall_and_wide_frames();
		src_idle_on = 1'b0;
		sink_idle_on = 1'b0;
		cfg_write(REG_WIDTH, 32'd1);
		cfg_write(REG_THRESH, 32'd127);
		send_pixels(30, 1'b0, 1'b1);
		settle();
		cfg_write(REG_WIDTH, DEF_MAX_WIDTH);
		send_pixels(40, 1'b0, 1'b1);
		settle();
	endtask

	task automatic test_width_change_mid_frame();
		src_idle_on = 1'b1;
		sink_idle_on = 1'b1;
		cfg_write(REG_WIDTH, 32'd3);
		cfg_write(REG_THRESH, 32'd50);
		send_pixels(7, 1'b0, 1'b0);
		settle();
		cfg_write(REG_WIDTH, 32'd5);
		cfg_write(REG_THRESH, 32'd20);
		send_pixels(9, 1'b0, 1'b1);
		settle();
	endtask

	task automatic test_result_backpressure();
		cfg_write(REG_WIDTH, 32'd4);
		cfg_write(REG_THRESH, $urandom_range(0, 200));
		src_idle_on = 1'b0;
		sink_idle_on = 1'b1;
		sink_hold = 300;
		repeat (30) send_pixels($urandom_range(1, 3), 1'b0, 1'b1);
		settle();
	endtask

	task automatic test_random_frames();
		int start;
		int len;
		logic [31:0] thr;
		logic [31:0] wid;
		start = pixels_sent;
		while (pixels_sent - start < 250) begin
			case ($urandom_range(0, 5))
				0: thr = 0;
				1: thr = 255;
				default: thr = $urandom_range(0, 255);
			endcase
			case ($urandom_range(0, 9))
				0: wid = 0;
				1: wid = DEF_MAX_WIDTH;
				2: wid = 8191;
				3: wid = $urandom_range(4097, 8190);
				4: wid = $urandom_range(13, 300);
				default: wid = $urandom_range(1, 12);
			endcase
			cfg_write(REG_THRESH, thr);
			cfg_write(REG_WIDTH, wid);
			src_idle_on = ($urandom_range(0, 3) != 0);
			sink_idle_on = ($urandom_range(0, 3) != 0);
			repeat ($urandom_range(4, 9)) begin
				len = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
				send_pixels(len, $urandom_range(0, 5) == 0, 1'b1);
			end
			settle();
		end
	endtask

	initial begin : stimulus
		int n;
		arst_n = 1'b0;
		push = 1'b0;
		pixel = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		m_thresh = THRESH_RESET;
		m_width = WIDTH_RESET;
		clear_frame_sums();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_register_defaults();
		test_directed_frames();
		test_tall_and_wide_frames();
		test_width_change_mid_frame();
		test_result_backpressure();
		test_random_frames();

		@(negedge clk);
		push = 1'b0;
		for (n = 0; n < 5000 && frame_results_q.size() != 0; n++)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (frame_results_q.size() != 0) begin
			$display("%0d frame results never arrived", frame_results_q.size());
			errors += frame_results_q.size();
		end

		$display("covered %0d pixels, %0d frame results: corner frames, tall/wide frames,",
			pixels_sent, frames_checked);
		$display("mid-frame width change, random settings; input stalled %0d cycles, %0d mismatches",
			stall_cycles, errors);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
